>>> rtl/sorted_list_table_unit_assert.svh
// Assertion macros for the sorted list table RTL.
// Each expands to a labeled concurrent assertion on clk, disabled in reset.
`ifndef SORTED_LIST_TABLE_UNIT_ASSERT_SVH
`define SORTED_LIST_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SLT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SLT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/slt_pkg.sv
`timescale 1ns / 1ps
package slt_pkg;

  localparam int DATA_W = 32;
  localparam int OP_W   = 2;
  localparam int POS_W  = 6;
  localparam int ST_W   = 3;
  localparam int TOT_W  = 7;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_FIND   = 2'd3
  } slt_op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_BAD_POS   = 3'd3,
    ST_FULL      = 3'd4
  } slt_status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_CMP  = 2'd1,
    S_UPD  = 2'd2
  } slt_state_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic                     cmp_en;
    logic                     ins_en;
    logic                     rem_en;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
  } slt_ctl_t;

endpackage

>>> rtl/slt_if.sv
`timescale 1ns / 1ps
// Request channel: one operation word.
interface slt_req_if;
  logic                                valid;
  logic                                ready;
  logic [slt_pkg::OP_W-1:0]            operation;
  logic signed [slt_pkg::DATA_W-1:0]   value;
  logic [slt_pkg::POS_W-1:0]           position;

  modport source (output valid, operation, value, position, input ready);
  modport sink   (input valid, operation, value, position, output ready);
endinterface

// Response channel: one result word.
interface slt_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [slt_pkg::ST_W-1:0]            status;
  logic signed [slt_pkg::DATA_W-1:0]   read_value;
  logic [slt_pkg::POS_W-1:0]           found_position;
  logic [slt_pkg::TOT_W-1:0]           entry_total;

  modport source (output valid, status, read_value, found_position, entry_total,
                  input ready);
  modport sink   (input valid, status, read_value, found_position, entry_total,
                  output ready);
endinterface

>>> rtl/slt_cell.sv
`timescale 1ns / 1ps
// One slot of the sorted chain. Holds one entry, compares it against the
// broadcast value, and shifts toward a neighbor on insert or remove.
module slt_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  logic                             clk,
  input  slt_pkg::slt_ctl_t                ctl,
  input  logic [CNT_W-1:0]                 count,
  input  logic                             left_lt,
  input  logic signed [slt_pkg::DATA_W-1:0] left_entry,
  input  logic signed [slt_pkg::DATA_W-1:0] right_entry,
  output logic signed [slt_pkg::DATA_W-1:0] entry,
  output logic                             lt,
  output logic                             eq,
  output logic signed [slt_pkg::DATA_W-1:0] rd_term
);

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);
  localparam bit REACH = (IDX < (1 << slt_pkg::POS_W));

  logic vld;
  logic hit;

  assign vld = (IDX_C < count);

  // compare flags, held through the update cycle
  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      lt  <= vld && (entry < ctl.value);
      eq  <= vld && (entry == ctl.value);
      hit <= REACH && (ctl.position == slt_pkg::POS_W'(IDX));
    end
  end

  // insert: first slot not below value takes it, later slots shift right
  // remove: slots at or past the first match pull from the right
  always_ff @(posedge clk) begin
    if (ctl.ins_en) begin
      if (left_lt && !lt) begin
        entry <= ctl.value;
      end else if (!left_lt) begin
        entry <= left_entry;
      end
    end else if (ctl.rem_en) begin
      if (!lt) begin
        entry <= right_entry;
      end
    end
  end

  assign rd_term = hit ? entry : '0;

endmodule

>>> rtl/sorted_list_table_unit.sv
`timescale 1ns / 1ps
// Channel  Dir  Word fields
// -------  ---  ------------------------------------------------
// req      in   operation[1:0], value[31:0] signed, position[5:0]
// rsp      out  status[2:0], read_value[31:0] signed,
//               found_position[5:0], entry_total[6:0]
//
// Every operation passes through accept, parallel compare in all cells,
// then shift/update with the result loaded into the output register.
// The next word is taken once the update cycle has fired.
// Reset empties the table (count to zero); no clearing pass is needed.
// A stalled response holds the update cycle until the output register frees.
module sorted_list_table_unit #(
  parameter int CAPACITY = 64
) (
  input  logic       clk,
  input  logic       rst,
  slt_req_if.sink    req,
  slt_rsp_if.source  rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMP_W = (CNT_W > slt_pkg::POS_W) ? CNT_W : slt_pkg::POS_W;
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  slt_pkg::slt_state_t state, state_next;

  // latched request
  slt_pkg::slt_op_t                  op;
  logic signed [slt_pkg::DATA_W-1:0] value;
  logic [slt_pkg::POS_W-1:0]         position;

  logic [CNT_W-1:0] count, count_next;

  // result register
  logic                              rsp_vld;
  slt_pkg::slt_status_t              res_status;
  logic signed [slt_pkg::DATA_W-1:0] res_read;
  logic [slt_pkg::POS_W-1:0]         res_found;

  // cell chain
  slt_pkg::slt_ctl_t                 ctl;
  logic signed [slt_pkg::DATA_W-1:0] entry   [CAPACITY];
  logic signed [slt_pkg::DATA_W-1:0] rd_term [CAPACITY];
  logic [CAPACITY-1:0]               lt;
  logic [CAPACITY-1:0]               eq;
  logic [CAPACITY-1:0]               first;

  logic                              found;
  logic [IDX_W-1:0]                  fp_enc;
  logic signed [slt_pkg::DATA_W-1:0] rd_or;
  logic                              fire;
  logic                              do_ins, do_rem;
  slt_pkg::slt_status_t              st_calc;
  logic signed [slt_pkg::DATA_W-1:0] rd_calc;
  logic [slt_pkg::POS_W-1:0]         fp_calc;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                              left_lt;
    logic signed [slt_pkg::DATA_W-1:0] left_entry;
    logic signed [slt_pkg::DATA_W-1:0] right_entry;

    if (i == 0) begin : g_head
      assign left_lt    = 1'b1;
      assign left_entry = entry[i];
    end else begin : g_mid
      assign left_lt    = lt[i-1];
      assign left_entry = entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = entry[i];
    end else begin : g_body
      assign right_entry = entry[i+1];
    end

    slt_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .count       (count),
      .left_lt     (left_lt),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (entry[i]),
      .lt          (lt[i]),
      .eq          (eq[i]),
      .rd_term     (rd_term[i])
    );
  end

  // first matching slot; matches are contiguous in a sorted chain
  always_comb begin
    first[0] = eq[0];
    for (int j = 1; j < CAPACITY; j++) begin
      first[j] = eq[j] & ~eq[j-1];
    end
  end

  // reductions over the registered cell flags
  always_comb begin
    found  = |eq;
    fp_enc = '0;
    rd_or  = '0;
    for (int j = 0; j < CAPACITY; j++) begin
      fp_enc = fp_enc | ({IDX_W{first[j]}} & IDX_W'(j));
      rd_or  = rd_or | rd_term[j];
    end
  end

  // result and count update
  always_comb begin
    st_calc    = slt_pkg::ST_OK;
    rd_calc    = '0;
    fp_calc    = '0;
    do_ins     = 1'b0;
    do_rem     = 1'b0;
    count_next = count;
    unique case (op)
      slt_pkg::OP_INSERT: begin
        if (count == CAP_C) begin
          st_calc = slt_pkg::ST_FULL;
        end else begin
          do_ins     = 1'b1;
          count_next = CNT_W'(count + 1'b1);
        end
      end
      slt_pkg::OP_REMOVE: begin
        if (count == '0) begin
          st_calc = slt_pkg::ST_EMPTY;
        end else if (!found) begin
          st_calc = slt_pkg::ST_NOT_FOUND;
        end else begin
          do_rem     = 1'b1;
          count_next = CNT_W'(count - 1'b1);
        end
      end
      slt_pkg::OP_READ: begin
        if (CMP_W'(position) >= CMP_W'(count)) begin
          st_calc = slt_pkg::ST_BAD_POS;
        end else begin
          rd_calc = rd_or;
        end
      end
      slt_pkg::OP_FIND: begin
        if (!found) begin
          st_calc = slt_pkg::ST_NOT_FOUND;
        end else begin
          fp_calc = slt_pkg::POS_W'(fp_enc);
        end
      end
      default: st_calc = slt_pkg::ST_OK;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    req.ready    = 1'b0;
    fire         = 1'b0;
    ctl.cmp_en   = 1'b0;
    ctl.ins_en   = 1'b0;
    ctl.rem_en   = 1'b0;
    ctl.value    = value;
    ctl.position = position;
    unique case (state)
      slt_pkg::S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = slt_pkg::S_CMP;
        end
      end
      slt_pkg::S_CMP: begin
        ctl.cmp_en = 1'b1;
        state_next = slt_pkg::S_UPD;
      end
      slt_pkg::S_UPD: begin
        fire       = !rsp_vld || rsp.ready;
        ctl.ins_en = fire && do_ins;
        ctl.rem_en = fire && do_rem;
        if (fire) begin
          state_next = slt_pkg::S_IDLE;
        end
      end
      default: state_next = slt_pkg::S_IDLE;
    endcase
  end

  // request latch
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op       <= slt_pkg::slt_op_t'(req.operation);
      value    <= req.value;
      position <= req.position;
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (fire) begin
      count <= count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_vld <= 1'b0;
    end else if (fire) begin
      rsp_vld <= 1'b1;
    end else if (rsp.ready) begin
      rsp_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_status <= st_calc;
      res_read   <= rd_calc;
      res_found  <= fp_calc;
    end
  end

  assign rsp.valid          = rsp_vld;
  assign rsp.status         = res_status;
  assign rsp.read_value     = res_read;
  assign rsp.found_position = res_found;
  assign rsp.entry_total    = slt_pkg::TOT_W'(count);

`include "sorted_list_table_unit_assert.svh"

  `SLT_ASSERT_NOW(a_count_bound, 1'b1, count <= CAP_C, "entry count above capacity")
  `SLT_ASSERT_NEXT(a_count_hold, state != slt_pkg::S_UPD, $stable(count), "count moved outside update")
  `SLT_ASSERT_NOW(a_first_match, state == slt_pkg::S_UPD, $onehot0(first), "match slots not contiguous")
  `SLT_ASSERT_NEXT(a_fire_result, fire, rsp.valid && state == slt_pkg::S_IDLE, "update fired without result")

endmodule
